>>> rtl/ddo_pkg.sv
package ddo_pkg;

  localparam logic [1:0] CFG_TICK_TO_RADIAN = 2'd0;
  localparam logic [1:0] CFG_ROLL_RADIUS    = 2'd1;
  localparam logic [1:0] CFG_TRACK_WIDTH    = 2'd2;

  localparam logic [31:0] TICK_TO_RADIAN_RESET = 32'd6588397;
  localparam logic [23:0] ROLL_RADIUS_RESET    = 24'd2163;
  localparam logic [23:0] TRACK_WIDTH_RESET    = 24'd10486;

  localparam logic [63:0] INV_TWO_PI_Q64    = 64'h28BE60DB9391054A;
  localparam logic [33:0] CORDIC_GAIN       = 34'd652032874;
  localparam logic [62:0] SAT63             = {63{1'b1}};
  localparam logic [63:0] MICROS_PER_SECOND = 64'd1000000;

  typedef struct packed {
    logic signed [32:0] dif;
    logic signed [32:0] sum;
    logic [31:0]        dt;
  } step_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RT, B_DS, B_THM, B_THD, B_ANG, B_CORDIC,
    B_XS, B_YS, B_LM, B_LD, B_AM, B_AD, B_OUT
  } back_state_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 32'h20000000;
      5'd1:  atan_turn = 32'h12E4051E;
      5'd2:  atan_turn = 32'h09FB385B;
      5'd3:  atan_turn = 32'h051111D4;
      5'd4:  atan_turn = 32'h028B0D43;
      5'd5:  atan_turn = 32'h0145D7E1;
      5'd6:  atan_turn = 32'h00A2F61E;
      5'd7:  atan_turn = 32'h00517C55;
      5'd8:  atan_turn = 32'h0028BE53;
      5'd9:  atan_turn = 32'h00145F2F;
      5'd10: atan_turn = 32'h000A2F98;
      5'd11: atan_turn = 32'h000517CC;
      5'd12: atan_turn = 32'h00028BE6;
      5'd13: atan_turn = 32'h000145F3;
      5'd14: atan_turn = 32'h0000A2FA;
      5'd15: atan_turn = 32'h0000517D;
      5'd16: atan_turn = 32'h000028BE;
      5'd17: atan_turn = 32'h0000145F;
      5'd18: atan_turn = 32'h00000A30;
      5'd19: atan_turn = 32'h00000518;
      5'd20: atan_turn = 32'h0000028C;
      5'd21: atan_turn = 32'h00000146;
      5'd22: atan_turn = 32'h000000A3;
      5'd23: atan_turn = 32'h00000051;
      5'd24: atan_turn = 32'h00000029;
      5'd25: atan_turn = 32'h00000014;
      5'd26: atan_turn = 32'h0000000A;
      5'd27: atan_turn = 32'h00000005;
      5'd28: atan_turn = 32'h00000003;
      5'd29: atan_turn = 32'h00000001;
      5'd30: atan_turn = 32'h00000001;
      default: atan_turn = 32'h00000000;
    endcase
  endfunction

endpackage

>>> rtl/ddo_front.sv
module ddo_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  left_position,
  input  logic signed [31:0]  right_position,
  input  logic [31:0]         elapsed_time,
  input  logic                q_full,
  output logic                q_push,
  output ddo_pkg::step_t      q_data
);
  import ddo_pkg::*;

  logic [31:0]        previous_left;
  logic [31:0]        previous_right;
  logic               first_pending;
  logic               accept;
  logic signed [31:0] dl;
  logic signed [31:0] dr;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign dl = left_position - previous_left;
  assign dr = right_position - previous_right;

  always_comb begin
    q_data.dif = 33'(dl) - 33'(dr);
    q_data.sum = 33'(dl) + 33'(dr);
    q_data.dt  = elapsed_time;
  end

  assign q_push = accept && !first_pending && (elapsed_time != 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_left  <= '0;
      previous_right <= '0;
      first_pending  <= 1'b1;
    end else if (accept) begin
      previous_left  <= left_position;
      previous_right <= right_position;
      first_pending  <= 1'b0;
    end
  end
endmodule

>>> rtl/ddo_queue.sv
module ddo_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ddo_pkg::step_t push_data,
  input  logic           pop,
  output ddo_pkg::step_t head,
  output logic           full,
  output logic           empty
);
  import ddo_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  step_t         entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

>>> rtl/ddo_mul.sv
module ddo_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] product
);
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [1:0]   step;
  logic         busy;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_shifted;

  assign pa = step[1] ? a_r[63:32] : a_r[31:0];
  assign pb = step[0] ? b_r[63:32] : b_r[31:0];
  assign pp = pa * pb;

  always_comb begin
    case (step)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd3:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= a;
      b_r     <= b;
      product <= '0;
    end else if (busy) begin
      product <= product + pp_shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/ddo_div.sv
module ddo_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [95:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [95:0] quotient
);
  localparam int BITS_PER_CYCLE = 4;
  localparam int CYCLES = 96 / BITS_PER_CYCLE;

  logic [31:0] d_r;
  logic [31:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [31:0] rem_next;
  logic [95:0] quot_next;

  always_comb begin
    logic [32:0] t;
    rem_next  = rem;
    quot_next = quotient;
    for (int j = 0; j < BITS_PER_CYCLE; j++) begin
      t = {rem_next, quot_next[95]};
      quot_next = {quot_next[94:0], 1'b0};
      if (t >= {1'b0, d_r}) begin
        rem_next     = 32'(t - {1'b0, d_r});
        quot_next[0] = 1'b1;
      end else begin
        rem_next = t[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'(CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/ddo_back.sv
module ddo_back #(
  parameter int ROTATION_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  ddo_pkg::step_t     q_head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [31:0]        tick_to_radian,
  input  logic [23:0]        roll_radius,
  input  logic [23:0]        track_width,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_position,
  output logic signed [31:0] y_position,
  output logic [31:0]        heading_angle,
  output logic signed [31:0] linear_velocity,
  output logic signed [31:0] angular_velocity
);
  import ddo_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic               issue;
  step_t              cur;
  logic [55:0]        rt;
  logic [62:0]        ds_mag;
  logic [62:0]        th_mag;
  logic               flip;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [33:0] cz;
  logic [5:0]         cnt;
  logic [31:0]        pose_x;
  logic [31:0]        pose_y;
  logic [31:0]        pose_heading;
  logic [31:0]        lin;
  logic [31:0]        ang;

  logic               mul_start;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic               mul_done;
  logic [127:0]       prod;
  logic               div_start;
  logic [95:0]        div_n;
  logic [31:0]        div_d;
  logic               div_done;
  logic [95:0]        quot;

  logic               ds_neg;
  logic               th_neg;
  logic [32:0]        dif_abs;
  logic [32:0]        sum_abs;
  logic signed [33:0] trig_c;
  logic signed [33:0] trig_s;
  logic [33:0]        abs_c;
  logic [33:0]        abs_s;
  logic [23:0]        w_eff;
  logic [31:0]        full_turn;
  logic [31:0]        half_turn;
  logic [31:0]        angle;
  logic [31:0]        angle_rot;
  logic [31:0]        adv_pose;
  logic               adv_neg;
  logic [31:0]        adv_result;
  logic [31:0]        rate_result;
  logic               rate_neg;
  logic               can_load;

  ddo_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (quot)
  );

  assign ds_neg  = cur.dif < 0;
  assign th_neg  = cur.sum > 0;
  assign dif_abs = ds_neg ? 33'(-cur.dif) : 33'(cur.dif);
  assign sum_abs = (cur.sum < 0) ? 33'(-cur.sum) : 33'(cur.sum);
  assign w_eff   = (track_width == '0) ? 24'd1 : track_width;
  assign trig_c  = flip ? -cx : cx;
  assign trig_s  = flip ? -cy : cy;
  assign abs_c   = (trig_c < 0) ? 34'(-trig_c) : 34'(trig_c);
  assign abs_s   = (trig_s < 0) ? 34'(-trig_s) : 34'(trig_s);
  assign can_load = !out_valid || !out_stall;

  // heading step and half step in binary angle
  always_comb begin
    full_turn = th_neg ? 32'(-prod[95:64]) : prod[95:64];
    half_turn = th_neg ? 32'(-prod[96:65]) : prod[96:65];
    angle     = pose_heading + half_turn;
    angle_rot = angle + 32'h80000000;
  end

  // position step: ds * trig >> 46, capped, then saturating add
  always_comb begin
    logic [81:0]        m;
    logic [32:0]        mag;
    logic signed [34:0] acc;
    adv_pose = (state == B_XS) ? pose_x : pose_y;
    adv_neg  = ds_neg ^ ((state == B_XS) ? (trig_c < 0) : (trig_s < 0));
    m   = prod[127:46];
    mag = (m > 82'h1_0000_0000) ? 33'h1_0000_0000 : m[32:0];
    acc = 35'(signed'(adv_pose)) + (adv_neg ? -35'(mag) : 35'(mag));
    if (acc > 35'sh0_7FFF_FFFF) begin
      adv_result = 32'h7FFFFFFF;
    end else if (acc < -35'sh0_8000_0000) begin
      adv_result = 32'h80000000;
    end else begin
      adv_result = acc[31:0];
    end
  end

  // velocity: quotient >> 16, saturated by sign
  always_comb begin
    logic [79:0] m;
    rate_neg = (state == B_LD) ? ds_neg : th_neg;
    m = quot[95:16];
    if (!rate_neg) begin
      rate_result = (m > 80'h7FFF_FFFF) ? 32'h7FFFFFFF : m[31:0];
    end else begin
      rate_result = (m > 80'h8000_0000) ? 32'h80000000 : 32'(-m[31:0]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (!q_empty) state_next = B_RT;
      B_RT:     if (mul_done) state_next = B_DS;
      B_DS:     if (mul_done) state_next = B_THM;
      B_THM:    if (mul_done) state_next = B_THD;
      B_THD:    if (div_done) state_next = B_ANG;
      B_ANG:    if (mul_done) state_next = B_CORDIC;
      B_CORDIC: if (cnt == 6'(ROTATION_STEPS)) state_next = B_XS;
      B_XS:     if (mul_done) state_next = B_YS;
      B_YS:     if (mul_done) state_next = B_LM;
      B_LM:     if (mul_done) state_next = B_LD;
      B_LD:     if (div_done) state_next = B_AM;
      B_AM:     if (mul_done) state_next = B_AD;
      B_AD:     if (div_done) state_next = B_OUT;
      B_OUT:    if (can_load) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = {8'd0, rt};
    mul_b     = '0;
    div_n     = prod[95:0];
    div_d     = cur.dt;
    q_pop     = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop = !q_empty;
      end
      B_RT: begin
        mul_start = issue;
        mul_a     = {40'd0, roll_radius};
        mul_b     = {32'd0, tick_to_radian};
      end
      B_DS: begin
        mul_start = issue;
        mul_b     = {31'd0, dif_abs};
      end
      B_THM: begin
        mul_start = issue;
        mul_b     = {31'd0, sum_abs};
      end
      B_THD: begin
        div_start = issue;
        div_d     = {8'd0, w_eff};
      end
      B_ANG: begin
        mul_start = issue;
        mul_a     = {1'b0, th_mag};
        mul_b     = INV_TWO_PI_Q64;
      end
      B_XS: begin
        mul_start = issue;
        mul_a     = {1'b0, ds_mag};
        mul_b     = {30'd0, abs_c};
      end
      B_YS: begin
        mul_start = issue;
        mul_a     = {1'b0, ds_mag};
        mul_b     = {30'd0, abs_s};
      end
      B_LM: begin
        mul_start = issue;
        mul_a     = {1'b0, ds_mag};
        mul_b     = MICROS_PER_SECOND;
      end
      B_AM: begin
        mul_start = issue;
        mul_a     = {1'b0, th_mag};
        mul_b     = MICROS_PER_SECOND;
      end
      B_LD, B_AD: begin
        div_start = issue;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      issue <= 1'b0;
    end else begin
      state <= state_next;
      issue <= (state_next != state);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] ys;
    logic signed [33:0] xs;
    logic [4:0]         i;
    i  = cnt[4:0];
    ys = cy >>> i;
    xs = cx >>> i;
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == B_RT && mul_done) begin
      rt <= prod[55:0];
    end
    if (state == B_DS && mul_done) begin
      ds_mag <= (prod[127:80] != '0) ? SAT63 : prod[79:17];
    end
    if (state == B_THD && div_done) begin
      th_mag <= (quot[95:63] != '0) ? SAT63 : quot[62:0];
    end
    if (state == B_ANG && mul_done) begin
      flip <= angle[31] ^ angle[30];
      cx   <= CORDIC_GAIN;
      cy   <= '0;
      cz   <= (angle[31] ^ angle[30]) ? 34'(signed'(angle_rot)) : 34'(signed'(angle));
      cnt  <= '0;
    end
    if (state == B_CORDIC && cnt != 6'(ROTATION_STEPS)) begin
      if (cz >= 0) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - 34'(atan_turn(i));
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + 34'(atan_turn(i));
      end
      cnt <= cnt + 1'b1;
    end
    if (state == B_LD && div_done) begin
      lin <= rate_result;
    end
    if (state == B_AD && div_done) begin
      ang <= rate_result;
    end
    if (state == B_OUT && can_load) begin
      x_position       <= pose_x;
      y_position       <= pose_y;
      heading_angle    <= pose_heading;
      linear_velocity  <= lin;
      angular_velocity <= ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == B_ANG && mul_done) begin
        pose_heading <= pose_heading + full_turn;
      end
      if (state == B_XS && mul_done) begin
        pose_x <= adv_result;
      end
      if (state == B_YS && mul_done) begin
        pose_y <= adv_result;
      end
      if (state == B_OUT && can_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

>>> rtl/differential_drive_odometry_top.sv
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   left_position, right_position, elapsed_time
// out       output     out_valid/out_stall x_position, y_position, heading_angle,
//                                          linear_velocity, angular_velocity
// cfg       input      cfg_write_enable    cfg_index, cfg_data
//
// A transaction that yields a pose uses in the back end:
// eight multiplies on one 32x32 multiplier (start, four partial products, done),
// three radix-16 divides, ROTATION_STEPS CORDIC rotations, and one step each to
// pick up from the queue and to load the result register.
// The front takes a transaction every cycle while the 2-entry queue has room.
// Reset is synchronous; first sample and zero elapsed time give no result.
// out_stall holds the result register; the back end finishes the next pose and waits.
module differential_drive_odometry_top #(
  parameter int ROTATION_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] left_position,
  input  logic signed [31:0] right_position,
  input  logic [31:0]        elapsed_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_position,
  output logic signed [31:0] y_position,
  output logic [31:0]        heading_angle,
  output logic signed [31:0] linear_velocity,
  output logic signed [31:0] angular_velocity,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ddo_pkg::*;

  logic [31:0] tick_to_radian;
  logic [23:0] roll_radius;
  logic [23:0] track_width;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  step_t       q_data;
  step_t       q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_to_radian <= TICK_TO_RADIAN_RESET;
      roll_radius    <= ROLL_RADIUS_RESET;
      track_width    <= TRACK_WIDTH_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_TICK_TO_RADIAN: tick_to_radian <= cfg_data;
        CFG_ROLL_RADIUS:    roll_radius    <= cfg_data[23:0];
        CFG_TRACK_WIDTH:    track_width    <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  ddo_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .left_position  (left_position),
    .right_position (right_position),
    .elapsed_time   (elapsed_time),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  ddo_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ddo_back #(
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_head           (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .tick_to_radian   (tick_to_radian),
    .roll_radius      (roll_radius),
    .track_width      (track_width),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .x_position       (x_position),
    .y_position       (y_position),
    .heading_angle    (heading_angle),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity)
  );
endmodule

>>> sim/ddo_pose_checker.sv
`timescale 1ns / 100ps

module ddo_pose_checker #(
  parameter int ROTATION_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] left_position,
  input  logic signed [31:0] right_position,
  input  logic [31:0]        elapsed_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] x_position,
  input  logic signed [31:0] y_position,
  input  logic [31:0]        heading_angle,
  input  logic signed [31:0] linear_velocity,
  input  logic signed [31:0] angular_velocity,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 pending,
  output int                 errors
);
  import ddo_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] heading;
    logic [31:0] lin_vel;
    logic [31:0] ang_vel;
  } pose_result_t;

  pose_result_t pose_q[$];

  logic [31:0] tick_rad;
  logic [23:0] radius;
  logic [23:0] separation;
  logic [31:0] last_left, last_right, pose_x, pose_y, pose_heading;
  logic        awaiting_first;

  assign pending = pose_q.size();

  function automatic logic [63:0] sat_q63(input logic [127:0] v);
    return (v > {65'b0, SAT63}) ? {1'b0, SAT63} : v[63:0];
  endfunction

  function automatic logic [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] cap_q16(input logic [127:0] v);
    return (v > 128'h1_0000_0000) ? 64'h1_0000_0000 : v[63:0];
  endfunction

  task automatic sin_cos(input logic [31:0] angle, output longint c, output longint s);
    logic   flip;
    longint x, y, z, nx;
    flip = angle[31] ^ angle[30];
    if (flip) angle = angle + 32'h80000000;
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = longint'($signed(angle));
    for (int i = 0; i < ROTATION_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'({32'b0, atan_turn(i[4:0])});
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'({32'b0, atan_turn(i[4:0])});
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [31:0] step_pose(input logic [31:0] p, input logic [63:0] mag,
                                            input logic neg_ds, input longint trig);
    logic [127:0] prod;
    logic [63:0]  tmag, m;
    logic         neg;
    neg  = neg_ds != (trig < 0);
    tmag = (trig < 0) ? -trig : trig;
    prod = ({64'b0, mag} * {64'b0, tmag}) >> 46;
    m    = cap_q16(prod);
    return clamp_s32(longint'($signed(p)) + (neg ? -longint'(m) : longint'(m)));
  endfunction

  function automatic logic [31:0] velocity(input logic [63:0] mag, input logic neg,
                                           input logic [31:0] dt);
    logic [127:0] prod;
    logic [63:0]  m;
    prod = ({64'b0, mag} * {64'b0, MICROS_PER_SECOND}) / {96'b0, dt};
    m    = cap_q16(prod >> 16);
    return clamp_s32(neg ? -longint'(m) : longint'(m));
  endfunction

  task automatic predict_odometry(input logic [31:0] l, input logic [31:0] r,
                                  input logic [31:0] dt);
    logic signed [31:0] dl, dr;
    longint             dif, sum, c, s;
    logic [63:0]        rt, ds_mag, th_mag, w, adif, asum;
    logic [127:0]       prod;
    logic [31:0]        full, half;
    logic               ds_neg, th_neg;
    pose_result_t       res;
    if (awaiting_first) begin
      last_left = l;
      last_right = r;
      awaiting_first = 1'b0;
      return;
    end
    dl = l - last_left;
    dr = r - last_right;
    last_left = l;
    last_right = r;
    if (dt == 0) return;
    rt     = {40'b0, radius} * {32'b0, tick_rad};
    dif    = longint'(dl) - longint'(dr);
    sum    = longint'(dl) + longint'(dr);
    ds_neg = dif < 0;
    th_neg = sum > 0;
    adif   = (dif < 0) ? -dif : dif;
    asum   = (sum < 0) ? -sum : sum;
    prod   = ({64'b0, rt} * {64'b0, adif}) >> 17;
    ds_mag = sat_q63(prod);
    w      = (separation == 0) ? 64'd1 : {40'b0, separation};
    prod   = ({64'b0, rt} * {64'b0, asum}) / {64'b0, w};
    th_mag = sat_q63(prod);
    prod   = {64'b0, th_mag} * {64'b0, INV_TWO_PI_Q64};
    full   = prod[95:64];
    half   = prod[96:65];
    if (th_neg) begin
      full = -full;
      half = -half;
    end
    sin_cos(pose_heading + half, c, s);
    pose_heading = pose_heading + full;
    pose_x = step_pose(pose_x, ds_mag, ds_neg, c);
    pose_y = step_pose(pose_y, ds_mag, ds_neg, s);
    res.x       = pose_x;
    res.y       = pose_y;
    res.heading = pose_heading;
    res.lin_vel = velocity(ds_mag, ds_neg, dt);
    res.ang_vel = velocity(th_mag, th_neg, dt);
    pose_q.push_back(res);
  endtask

  task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s expected %h got %h", $realtime, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    pose_result_t e;
    if (rst) begin
      tick_rad       = TICK_TO_RADIAN_RESET;
      radius         = ROLL_RADIUS_RESET;
      separation     = TRACK_WIDTH_RESET;
      last_left      = '0;
      last_right     = '0;
      awaiting_first = 1'b1;
      pose_x         = '0;
      pose_y         = '0;
      pose_heading   = '0;
      pose_q.delete();
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_TICK_TO_RADIAN: tick_rad = cfg_data;
          CFG_ROLL_RADIUS:    radius = cfg_data[23:0];
          CFG_TRACK_WIDTH:    separation = cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          report("unexpected transaction x", 'x, x_position);
        end else begin
          e = pose_q.pop_front();
          if (x_position !== e.x) report("x_position", e.x, x_position);
          if (y_position !== e.y) report("y_position", e.y, y_position);
          if (heading_angle !== e.heading) report("heading_angle", e.heading, heading_angle);
          if (linear_velocity !== e.lin_vel)
            report("linear_velocity", e.lin_vel, linear_velocity);
          if (angular_velocity !== e.ang_vel)
            report("angular_velocity", e.ang_vel, angular_velocity);
        end
      end
      if (in_valid && !in_stall)
        predict_odometry(left_position, right_position, elapsed_time);
    end
  end

  initial errors = 0;

endmodule

>>> sim/tb_differential_drive_odometry_top.sv
`timescale 1ns / 100ps

module tb_differential_drive_odometry_top;
  import ddo_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] left_position = '0;
  logic signed [31:0] right_position = '0;
  logic [31:0]        elapsed_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] x_position, y_position, linear_velocity, angular_velocity;
  logic [31:0]        heading_angle;
  logic               cfg_write_enable = 1'b0;
  logic [1:0]         cfg_index = CFG_TICK_TO_RADIAN;
  logic [31:0]        cfg_data = '0;
  int                 pending, errors;
  int                 send_idle = 0, stall_pct = 0;
  logic [31:0]        enc_left = '0, enc_right = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  differential_drive_odometry_top i_dut (.*);

  ddo_pose_checker i_checker (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
                             input logic [31:0] dt);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    left_position  <= l;
    right_position <= r;
    elapsed_time   <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic odometry_run(input int n);
    int    kind;
    logic [31:0] dt;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      dt = $urandom_range(50000, 500);
      if (kind < 70) begin
        enc_left  = enc_left + $urandom_range(4000) - 2000;
        enc_right = enc_right + $urandom_range(4000) - 2000;
      end else if (kind < 80) begin
        enc_left  = enc_left + $urandom_range(200) - 100;
        enc_right = enc_right + $urandom_range(200) - 100;
        dt = (kind < 75) ? 32'd0 : $urandom_range(3);
      end else if (kind < 90) begin
        enc_left  = $urandom;
        enc_right = $urandom;
        dt = $urandom;
      end else begin
        enc_left  = enc_left + $urandom_range(100000) - 50000;
        enc_right = -enc_left + $urandom_range(20) - 10;
        dt = $urandom_range(1, 1000000);
      end
      send_sample(enc_left, enc_right, dt);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(32'd100, 32'd100, 32'd1000);
    send_sample(32'd200, -32'd0, 32'd0);
    send_sample(32'd300, -32'd100, 32'd10000);
    send_sample(32'd400, 32'd0, 32'd10000);
    send_sample(32'd500, 32'd100, 32'd10000);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'd1);
    send_sample(32'hFFFFFFFF, 32'h00000000, 32'd1);
    send_sample(32'h00000000, 32'hFFFFFFFF, 32'd20000);
    send_sample(32'h00001000, 32'h00001000, 32'd20000);
    send_sample(32'h00000000, 32'h00000000, 32'hFFFFFFFF);
    drain();
    write_reg(CFG_TRACK_WIDTH, 32'hFF000000);
    send_sample(32'd50, 32'd10, 32'd5000);
    send_sample(32'd60, 32'd30, 32'd5000);
    drain();
    write_reg(CFG_TICK_TO_RADIAN, 32'hFFFFFFFF);
    write_reg(CFG_ROLL_RADIUS, 32'h00FFFFFF);
    write_reg(CFG_TRACK_WIDTH, 32'd1);
    send_sample(32'h40000000, 32'hC0000000, 32'd1);
    send_sample(32'h40000010, 32'hC0000000, 32'd1000);
    send_sample(32'h40000010, 32'hC0000010, 32'd1000);
    drain();
    write_reg(CFG_TICK_TO_RADIAN, TICK_TO_RADIAN_RESET);
    write_reg(CFG_ROLL_RADIUS, ROLL_RADIUS_RESET);
    write_reg(CFG_TRACK_WIDTH, TRACK_WIDTH_RESET);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 83 : (ph == 3) ? 36 : 0;
      stall_pct = (ph == 2) ? 83 : (ph == 3) ? 36 : 0;
      odometry_run(420);
      drain();
      case (ph)
        0: begin
          write_reg(CFG_TICK_TO_RADIAN, 32'd1);
          write_reg(CFG_ROLL_RADIUS, 32'd1);
          write_reg(CFG_TRACK_WIDTH, 32'h00FFFFFF);
        end
        1: begin
          write_reg(CFG_TICK_TO_RADIAN, $urandom);
          write_reg(CFG_ROLL_RADIUS, $urandom_range(200000, 1));
          write_reg(CFG_TRACK_WIDTH, $urandom_range(500000, 1));
        end
        2: begin
          write_reg(CFG_TICK_TO_RADIAN, $urandom_range(20000000, 1000000));
          write_reg(CFG_ROLL_RADIUS, $urandom_range(10000, 1000));
          write_reg(CFG_TRACK_WIDTH, $urandom_range(40000, 5000));
        end
        default: ;
      endcase
    end
    send_idle = 0;
    stall_pct = 0;
    drain();

    if (errors == 0)
      $display("differential_drive_odometry_top: match");
    else
      $display("differential_drive_odometry_top: mismatch");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("differential_drive_odometry_top: mismatch");
    $finish;
  end

endmodule
